[design/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg - shared types and constants for the ray/box slab intersect core
// Widths, register codes and the words passed between front, queue and back.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int CW         = 32;          // coordinate width
    localparam int FB         = 16;          // fractional bits
    localparam int QB         = CW - 1;      // quotient bits below saturation
    localparam int NAX        = 3;           // axes
    localparam int NLN        = 2 * NAX;     // divider lanes: min faces, then max faces
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CFG_AW     = 3;

    typedef logic [CW-1:0] t_word;

    typedef enum logic [CFG_AW-1:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_MAX_X,
        REG_MAX_Y,
        REG_MAX_Z
    } t_reg_idx;

    // Classified ray, front to back
    typedef struct packed {
        t_word [NAX-1:0]        org;
        t_word [NAX-1:0]        dir;
        logic  [NAX-1:0][CW:0]  num_lo;   // box_min - origin
        logic  [NAX-1:0][CW:0]  num_hi;   // box_max - origin
        logic                   par_miss; // parallel axis outside its slab
    } t_item;

endpackage

[design/rbsi_if.sv]
// ----------------------------------------------------------------------------
// rbsi_if - ray and result channels
// Valid/ready channels carrying one ray word and one result word.
// ----------------------------------------------------------------------------
interface rbsi_ray_if;
    logic                            valid;
    logic                            ready;
    logic signed [rbsi_pkg::CW-1:0]  origin_x;
    logic signed [rbsi_pkg::CW-1:0]  origin_y;
    logic signed [rbsi_pkg::CW-1:0]  origin_z;
    logic signed [rbsi_pkg::CW-1:0]  dir_x;
    logic signed [rbsi_pkg::CW-1:0]  dir_y;
    logic signed [rbsi_pkg::CW-1:0]  dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rbsi_res_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic signed [rbsi_pkg::CW-1:0]  t_near;
    logic signed [rbsi_pkg::CW-1:0]  t_far;
    logic signed [rbsi_pkg::CW-1:0]  near_x;
    logic signed [rbsi_pkg::CW-1:0]  near_y;
    logic signed [rbsi_pkg::CW-1:0]  near_z;
    logic signed [rbsi_pkg::CW-1:0]  far_x;
    logic signed [rbsi_pkg::CW-1:0]  far_y;
    logic signed [rbsi_pkg::CW-1:0]  far_z;

    modport source (output valid, hit, t_near, t_far, near_x, near_y, near_z,
                    far_x, far_y, far_z, input ready);
    modport sink   (input valid, hit, t_near, t_far, near_x, near_y, near_z,
                    far_x, far_y, far_z, output ready);
endinterface

[design/rbsi_front.sv]
// ----------------------------------------------------------------------------
// rbsi_front - ray intake and classification
// Holds the box registers, takes rays, forms slab numerators, flags misses.
// ----------------------------------------------------------------------------
module rbsi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rbsi_ray_if.sink                     i_ray,
    input  logic                         i_cfg_we,
    input  logic [rbsi_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [rbsi_pkg::CW-1:0]      i_cfg_data,
    output logic                         o_valid,
    output rbsi_pkg::t_item              o_item,
    input  logic                         i_full
);
    rbsi_pkg::t_word [rbsi_pkg::NAX-1:0] r_lo, r_hi;
    logic                                r_valid;
    rbsi_pkg::t_item                     r_item, n_item;
    logic                                take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < rbsi_pkg::NAX; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= rbsi_pkg::CW'(1) << rbsi_pkg::FB;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbsi_pkg::REG_MIN_X: r_lo[0] <= i_cfg_data;
                rbsi_pkg::REG_MIN_Y: r_lo[1] <= i_cfg_data;
                rbsi_pkg::REG_MIN_Z: r_lo[2] <= i_cfg_data;
                rbsi_pkg::REG_MAX_X: r_hi[0] <= i_cfg_data;
                rbsi_pkg::REG_MAX_Y: r_hi[1] <= i_cfg_data;
                rbsi_pkg::REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take        = !r_valid || !i_full;
    assign i_ray.ready = take;

    always_comb begin
        n_item.org = {i_ray.origin_z, i_ray.origin_y, i_ray.origin_x};
        n_item.dir = {i_ray.dir_z, i_ray.dir_y, i_ray.dir_x};
        n_item.par_miss = 1'b0;
        for (int a = 0; a < rbsi_pkg::NAX; a++) begin
            n_item.num_lo[a] = {r_lo[a][rbsi_pkg::CW-1], r_lo[a]}
                             - {n_item.org[a][rbsi_pkg::CW-1], n_item.org[a]};
            n_item.num_hi[a] = {r_hi[a][rbsi_pkg::CW-1], r_hi[a]}
                             - {n_item.org[a][rbsi_pkg::CW-1], n_item.org[a]};
            // parallel axis: origin must lie within the slab, faces included
            if (n_item.dir[a] == '0 &&
                ($signed(n_item.org[a]) < $signed(r_lo[a]) ||
                 $signed(n_item.org[a]) > $signed(r_hi[a])))
                n_item.par_miss = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_ray.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

[design/rbsi_fifo.sv]
// ----------------------------------------------------------------------------
// rbsi_fifo - short queue between front and back
// Flop-based first-in first-out buffer of classified rays.
// ----------------------------------------------------------------------------
module rbsi_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbsi_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output rbsi_pkg::t_item  o_item
);
    rbsi_pkg::t_item                 r_mem [rbsi_pkg::FIFO_DEPTH];
    logic [rbsi_pkg::FIFO_AW-1:0]    r_wp, r_rp;
    logic [rbsi_pkg::FIFO_AW:0]      r_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == (rbsi_pkg::FIFO_AW+1)'(rbsi_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (rbsi_pkg::FIFO_AW+1)'(do_push) - (rbsi_pkg::FIFO_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (rbsi_pkg::FIFO_AW+1)'(rbsi_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");
`endif
endmodule

[design/rbsi_back.sv]
// ----------------------------------------------------------------------------
// rbsi_back - slab arithmetic pipeline
// Six pipelined dividers, interval merge, point multiply, saturation.
// ----------------------------------------------------------------------------
module rbsi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rbsi_pkg::t_item  i_item,
    output logic             o_pop,
    rbsi_res_if.source       o_res
);
    localparam int CW  = rbsi_pkg::CW;
    localparam int FB  = rbsi_pkg::FB;
    localparam int QB  = rbsi_pkg::QB;
    localparam int NAX = rbsi_pkg::NAX;
    localparam int NLN = rbsi_pkg::NLN;
    localparam int PW  = 2 * CW - FB + 2;

    localparam logic [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [CW-1:0]     dmag;
        logic [CW+FB-1:0]  num;
        logic [CW-1:0]     rem;
        logic [QB-1:0]     quo;
    } t_lane;

    typedef struct packed {
        t_lane [NLN-1:0]            lane;
        rbsi_pkg::t_word [NAX-1:0]  org;
        rbsi_pkg::t_word [NAX-1:0]  dir;
        logic                       par_miss;
    } t_dstage;

    typedef struct packed {
        rbsi_pkg::t_word [NLN-1:0]  tv;
        rbsi_pkg::t_word [NAX-1:0]  org;
        rbsi_pkg::t_word [NAX-1:0]  dir;
        logic                       par_miss;
    } t_tstage;

    typedef struct packed {
        rbsi_pkg::t_word            tn;
        rbsi_pkg::t_word            tf;
        logic                       hit;
        rbsi_pkg::t_word [NAX-1:0]  org;
        rbsi_pkg::t_word [NAX-1:0]  dir;
    } t_mstage;

    typedef struct packed {
        logic [NLN-1:0][2*CW-1:0]   prod;
        logic [NLN-1:0]             neg;
        rbsi_pkg::t_word            tn;
        rbsi_pkg::t_word            tf;
        logic                       hit;
        rbsi_pkg::t_word [NAX-1:0]  org;
    } t_pstage;

    typedef struct packed {
        logic                       hit;
        rbsi_pkg::t_word            tn;
        rbsi_pkg::t_word            tf;
        rbsi_pkg::t_word [NLN-1:0]  pt;
    } t_ostage;

    logic          en;
    t_dstage       r_ds [QB+1];
    logic [QB:0]   r_dv;
    t_tstage       r_ts, n_ts;
    logic          r_tv;
    t_mstage       r_ms, n_ms;
    logic          r_mv;
    t_pstage       r_ps, n_ps;
    logic          r_pv;
    t_ostage       r_os, n_os;
    logic          r_ov;
    t_dstage       n_d0;

    // whole pipe advances together; stall only when the result is held
    assign en    = !r_ov || o_res.ready;
    assign o_pop = en;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_tv <= 1'b0;
            r_mv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= {r_dv[QB-1:0], i_valid};
            r_tv <= r_dv[QB];
            r_mv <= r_tv;
            r_pv <= r_mv;
            r_ov <= r_pv;
        end
    end

    // prepare: magnitudes, signs, saturation test, first partial remainder
    always_comb begin
        logic [CW:0]     nv;
        logic [CW:0]     nm;
        logic [CW-1:0]   dv;
        logic [2*CW-1:0] lhs, rhs;
        nv = '0;
        nm = '0;
        dv = '0;
        lhs = '0;
        rhs = '0;
        n_d0.org      = i_item.org;
        n_d0.dir      = i_item.dir;
        n_d0.par_miss = i_item.par_miss;
        for (int l = 0; l < NLN; l++) begin
            nv = (l < NAX) ? i_item.num_lo[l % NAX] : i_item.num_hi[l % NAX];
            dv = i_item.dir[l % NAX];
            nm = nv[CW] ? -nv : nv;
            n_d0.lane[l].dmag = dv[CW-1] ? -dv : dv;
            n_d0.lane[l].neg  = nv[CW] ^ dv[CW-1];
            n_d0.lane[l].num  = {nm[CW-1:0], {FB{1'b0}}};
            lhs = (2*CW)'(n_d0.lane[l].num);
            rhs = (2*CW)'(n_d0.lane[l].dmag) << QB;
            // quotient reaches 2^(CW-1) exactly when num >= dmag * 2^(CW-1)
            n_d0.lane[l].sat  = (lhs >= rhs);
            n_d0.lane[l].rem  = CW'(n_d0.lane[l].num >> QB);
            n_d0.lane[l].quo  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_ds[0] <= n_d0;
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int K = QB - j;
        t_dstage n_ds;

        always_comb begin
            logic [CW:0] r2;
            r2   = '0;
            n_ds = r_ds[j-1];
            for (int l = 0; l < NLN; l++) begin
                r2 = {r_ds[j-1].lane[l].rem, r_ds[j-1].lane[l].num[K]};
                if (r2 >= {1'b0, r_ds[j-1].lane[l].dmag}) begin
                    n_ds.lane[l].quo[K] = 1'b1;
                    n_ds.lane[l].rem    = CW'(r2 - {1'b0, r_ds[j-1].lane[l].dmag});
                end else begin
                    n_ds.lane[l].rem    = CW'(r2);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) r_ds[j] <= n_ds;
        end
    end

    // sign and saturate the crossing parameters
    always_comb begin
        logic [CW-1:0] qm;
        qm = '0;
        n_ts.org      = r_ds[QB].org;
        n_ts.dir      = r_ds[QB].dir;
        n_ts.par_miss = r_ds[QB].par_miss;
        for (int l = 0; l < NLN; l++) begin
            qm = r_ds[QB].lane[l].sat ? VMIN : {1'b0, r_ds[QB].lane[l].quo};
            if (r_ds[QB].lane[l].neg)
                n_ts.tv[l] = -qm;
            else
                n_ts.tv[l] = r_ds[QB].lane[l].sat ? VMAX : qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_ts <= n_ts;
    end

    // order each slab's crossings and merge into the running interval
    always_comb begin
        logic [CW-1:0] a, b, tn, tf;
        tn = VMIN;
        tf = VMAX;
        a  = '0;
        b  = '0;
        for (int x = 0; x < NAX; x++) begin
            if (r_ts.dir[x] != '0) begin
                a = r_ts.tv[x];
                b = r_ts.tv[x + NAX];
                if ($signed(a) > $signed(b)) begin
                    a = r_ts.tv[x + NAX];
                    b = r_ts.tv[x];
                end
                if ($signed(a) > $signed(tn)) tn = a;
                if ($signed(b) < $signed(tf)) tf = b;
            end
        end
        n_ms.tn  = tn;
        n_ms.tf  = tf;
        n_ms.hit = !r_ts.par_miss && !($signed(tn) > $signed(tf)) && !tf[CW-1];
        n_ms.org = r_ts.org;
        n_ms.dir = r_ts.dir;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_ms <= n_ms;
    end

    // direction times parameter, on magnitudes
    always_comb begin
        logic [CW-1:0] dm, tm, tv;
        dm = '0;
        tm = '0;
        tv = '0;
        n_ps.tn  = r_ms.tn;
        n_ps.tf  = r_ms.tf;
        n_ps.hit = r_ms.hit;
        n_ps.org = r_ms.org;
        for (int l = 0; l < NLN; l++) begin
            tv = (l < NAX) ? r_ms.tn : r_ms.tf;
            dm = r_ms.dir[l % NAX][CW-1] ? -r_ms.dir[l % NAX] : r_ms.dir[l % NAX];
            tm = tv[CW-1] ? -tv : tv;
            n_ps.prod[l] = (2*CW)'(dm) * (2*CW)'(tm);
            n_ps.neg[l]  = r_ms.dir[l % NAX][CW-1] ^ tv[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_ps <= n_ps;
    end

    // truncate, add origin, clamp; zero everything on a miss
    always_comb begin
        logic [PW-1:0] m, s;
        m = '0;
        s = '0;
        n_os.hit = r_ps.hit;
        n_os.tn  = r_ps.hit ? r_ps.tn : '0;
        n_os.tf  = r_ps.hit ? r_ps.tf : '0;
        for (int l = 0; l < NLN; l++) begin
            m = PW'(r_ps.prod[l] >> FB);
            if (r_ps.neg[l]) m = -m;
            s = m + PW'($signed(r_ps.org[l % NAX]));
            if ($signed(s) > $signed(PW'(VMAX)))
                n_os.pt[l] = VMAX;
            else if ($signed(s) < $signed({{(PW-CW){1'b1}}, VMIN}))
                n_os.pt[l] = VMIN;
            else
                n_os.pt[l] = s[CW-1:0];
            if (!r_ps.hit) n_os.pt[l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_os <= n_os;
    end

    assign o_res.valid  = r_ov;
    assign o_res.hit    = r_os.hit;
    assign o_res.t_near = r_os.tn;
    assign o_res.t_far  = r_os.tf;
    assign o_res.near_x = r_os.pt[0];
    assign o_res.near_y = r_os.pt[1];
    assign o_res.near_z = r_os.pt[2];
    assign o_res.far_x  = r_os.pt[3];
    assign o_res.far_y  = r_os.pt[4];
    assign o_res.far_z  = r_os.pt[5];

`ifndef ASSERT_OFF
    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_os.hit |-> $signed(r_os.tn) <= $signed(r_os.tf))
        else $error("hit with empty interval");
    a_hit_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_os.hit |-> !r_os.tf[CW-1])
        else $error("hit with box behind ray");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_os.hit |-> r_os.tn == '0 && r_os.tf == '0 && r_os.pt == '0)
        else $error("miss result not cleared");
`endif
endmodule

[design/ray_box_slab_intersect_core.sv]
// Pipeline: 38 register stages: front register, queue, prepare, 31 divide stages,
//   sign, merge, multiply, output. Throughput: one ray per cycle unless a result
//   is held at the output; set by the fully pipelined six-lane divider.
// Reset: synchronous active-low; clears all valid flags and queue pointers,
//   and loads the box with minimum corner 0 and maximum corner 1.0.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core - ray against axis-aligned box, slab method
// Front classifies rays against the configured box, a short queue decouples
// it from the arithmetic back end, which divides, merges and forms points.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rbsi_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [rbsi_pkg::CW-1:0]      i_cfg_data,
    rbsi_ray_if.sink                     i_ray,
    rbsi_res_if.source                   o_res
);
    // front to queue
    logic             fr_valid;
    rbsi_pkg::t_item  fr_item;
    logic             q_full;
    // queue to back
    logic             q_valid;
    rbsi_pkg::t_item  q_item;
    logic             bk_pop;

    // take rays, hold box registers, work out numerators and parallel misses
    rbsi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ray      (i_ray),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (fr_valid),
        .o_item     (fr_item),
        .i_full     (q_full)
    );

    // decouple: front keeps accepting while the back end is stalled, until the queue fills
    rbsi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // divide, merge, multiply, saturate; advance whenever the output drains
    rbsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (bk_pop),
        .o_res   (o_res)
    );
endmodule
